FILE: rtl/pwtk_pkg.sv
// shared types, widths and codes for the per-window top-k selector
// used by per_window_top_k_select, pwtk_merge, pwtk_drain, pwtk_checker and tb_top, no dependencies
`default_nettype none

package pwtk_pkg;

   localparam int MAX_WINDOWS = 256;
   localparam int MAX_KEEP    = 16;

   localparam int WIN_W    = $clog2(MAX_WINDOWS);
   localparam int IDX_W    = $clog2(MAX_KEEP);
   localparam int CNT_W    = $clog2(MAX_KEEP + 1);
   localparam int KEEP_W   = 5;
   localparam int WCOUNT_W = 9;
   localparam int ID_W     = 16;
   localparam int SCORE_W  = 32;

   // stream payload layout, lowest field first
   localparam int WINDOW_LSB = 0;
   localparam int ID_LSB     = WINDOW_LSB + 8;
   localparam int SCORE_LSB  = ID_LSB + ID_W;
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_USER_W = 1;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 9;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEEP    = 1'b0,
      CSR_WINDOWS = 1'b1
   } csr_index_type;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_DRAIN  = 1'b1
   } cmd_type;

   typedef struct packed {
      logic        [ID_W-1:0]    id;
      logic signed [SCORE_W-1:0] score;
   } entry_type;

   // one memory row holds a whole window: its fill count and its sorted list
   typedef struct packed {
      logic      [CNT_W-1:0]      count;
      entry_type [MAX_KEEP-1:0]   ent;
   } row_type;

   typedef struct packed {
      row_type              row;
      logic [CNT_W-1:0]     keep;
      entry_type            cand;
   } insert_req_type;

   typedef struct packed {
      logic                     load;
      logic [WIN_W-1:0]         window;
      logic [CNT_W-1:0]         count;
      entry_type [MAX_KEEP-1:0] ent;
   } drain_load_type;

   function automatic logic [CNT_W-1:0] cnt_min(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      cnt_min = (a > b) ? b : a;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/per_window_top_k_select.sv
// Per-window top-k selector. Each window's sorted list lives in one row of a single
// synchronous memory; a flip-flop per window marks rows written since reset or the
// last drain, so no clearing pass is needed and the block is ready straight out of
// reset. An accepted insert reads its row on acceptance; the parallel compare, sorted
// insertion and write-back of the row happen in the update state. Inserts that are
// absent or name a window at or beyond window_count leave the block idle. A drain
// loads the row, then sends its result beats (1 to 16 beats); the next item
// is taken once the final beat has been accepted. Only one item is in flight, so reads
// and writes of a row never overlap. Configuration writes are accepted every cycle.
// depends on pwtk_pkg, pwtk_ram, pwtk_merge, pwtk_drain
`default_nettype none

module per_window_top_k_select (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [pwtk_pkg::REQ_DATA_W-1:0]     req_tdata,  // window, candidate_id, score
   input  wire logic [pwtk_pkg::REQ_USER_W-1:0]     req_tuser,  // cmd, present
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pwtk_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // out_window, out_id, out_score
   output logic [pwtk_pkg::RSP_USER_W-1:0]          rsp_tuser,  // entry_valid
   output logic                                     rsp_tlast,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [pwtk_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [pwtk_pkg::CSR_DATA_W-1:0]     csr_data
);
   import pwtk_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_LOAD,
      ST_DRAIN
   } state_type;

   state_type               state_ff, state_in;
   logic [WIN_W-1:0]        win_ff, win_in;
   entry_type               cand_ff, cand_in;
   logic                    win_ok_ff, win_ok_in;
   logic [KEEP_W-1:0]       keep_ff, keep_in;
   logic [WCOUNT_W-1:0]     wcount_ff, wcount_in;
   logic [MAX_WINDOWS-1:0]  row_valid_ff, row_valid_in;

   logic                    accept;
   logic [WIN_W-1:0]        req_win;
   cmd_type                 req_cmd;
   logic                    req_present;
   logic                    req_win_ok;
   logic [CNT_W-1:0]        keep_eff;
   logic [$bits(row_type)-1:0] rd_data;
   row_type                 old_row;
   row_type                 new_row;
   insert_req_type          ins;
   drain_load_type          ld;

   assign req_win     = req_tdata[WINDOW_LSB +: WIN_W];
   assign req_cmd     = cmd_type'(req_tuser[0]);
   assign req_present = req_tuser[1];
   assign req_win_ok  = (WCOUNT_W'(req_win) < wcount_ff);
   assign req_tready  = (state_ff == ST_IDLE);
   assign accept      = req_tvalid && req_tready;
   assign csr_ready   = 1'b1;

   assign keep_eff = (CNT_W'(keep_ff) > CNT_W'(MAX_KEEP)) ? CNT_W'(MAX_KEEP) : CNT_W'(keep_ff);

   pwtk_ram #(
      .WIDTH($bits(row_type)),
      .DEPTH(MAX_WINDOWS)
   ) u_rows (
      .clock   (clock),
      .wr_en   (state_ff == ST_UPDATE),
      .wr_addr (win_ff),
      .wr_data (new_row),
      .rd_en   (accept),
      .rd_addr (req_win),
      .rd_data (rd_data)
   );

   // a row never written since reset or since its last drain reads as empty
   always_comb begin
      old_row = row_type'(rd_data);
      if (!row_valid_ff[win_ff]) begin
         old_row.count = '0;
      end
   end

   always_comb begin
      ins.row  = old_row;
      ins.keep = keep_eff;
      ins.cand = cand_ff;
   end

   pwtk_merge u_merge (
      .ins     (ins),
      .row_out (new_row)
   );

   always_comb begin
      ld.load   = (state_ff == ST_LOAD);
      ld.window = win_ff;
      ld.count  = win_ok_ff ? cnt_min(old_row.count, keep_eff) : '0;
      ld.ent    = old_row.ent;
   end

   pwtk_drain u_drain (
      .clock      (clock),
      .reset      (reset),
      .ld         (ld),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always_comb begin
      state_in     = state_ff;
      win_in       = win_ff;
      cand_in      = cand_ff;
      win_ok_in    = win_ok_ff;
      keep_in      = keep_ff;
      wcount_in    = wcount_ff;
      row_valid_in = row_valid_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_KEEP:    keep_in   = csr_data[KEEP_W-1:0];
            CSR_WINDOWS: wcount_in = csr_data[WCOUNT_W-1:0];
            default:     ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               win_in    = req_win;
               cand_in   = '{id: req_tdata[ID_LSB +: ID_W],
                             score: req_tdata[SCORE_LSB +: SCORE_W]};
               win_ok_in = req_win_ok;
               if (req_cmd == CMD_DRAIN) begin
                  state_in = ST_LOAD;
               end else if (req_present && req_win_ok) begin
                  state_in = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            row_valid_in[win_ff] = 1'b1;
            state_in             = ST_IDLE;
         end
         ST_LOAD: begin
            if (win_ok_ff) begin
               row_valid_in[win_ff] = 1'b0;
            end
            state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_tvalid && rsp_tready && rsp_tlast) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         keep_ff      <= KEEP_W'(16);
         wcount_ff    <= WCOUNT_W'(256);
         row_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         keep_ff      <= keep_in;
         wcount_ff    <= wcount_in;
         row_valid_ff <= row_valid_in;
      end
      win_ff    <= win_in;
      cand_ff   <= cand_in;
      win_ok_ff <= win_ok_in;
   end

endmodule

`default_nettype wire

FILE: rtl/pwtk_ram.sv
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`default_nettype none

module pwtk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/pwtk_merge.sv
// sorted insertion of one candidate into a window row read from memory
// depends on pwtk_pkg
`default_nettype none

module pwtk_merge (
   input  wire pwtk_pkg::insert_req_type ins,
   output pwtk_pkg::row_type             row_out
);
   import pwtk_pkg::*;

   logic [CNT_W-1:0]    n;
   logic [MAX_KEEP-1:0] ge;
   logic [IDX_W-1:0]    bottom;

   always_comb begin
      n      = cnt_min(ins.row.count, ins.keep);
      bottom = IDX_W'(ins.keep - CNT_W'(1));

      // entries that stay ahead of the newcomer form a prefix of the list
      for (int i = 0; i < MAX_KEEP; i++) begin
         ge[i] = (CNT_W'(i) < n) && (ins.row.ent[i].score >= ins.cand.score);
      end

      // each slot keeps its entry, takes the newcomer or takes its upper neighbour
      row_out.ent[0] = ge[0] ? ins.row.ent[0] : ins.cand;
      for (int i = 1; i < MAX_KEEP; i++) begin
         if (ge[i]) begin
            row_out.ent[i] = ins.row.ent[i];
         end else if (ge[i-1]) begin
            row_out.ent[i] = ins.cand;
         end else begin
            row_out.ent[i] = ins.row.ent[i-1];
         end
      end

      if (ins.keep == '0) begin
         row_out.count = '0;
      end else if (ge[bottom]) begin
         // newcomer only ties or trails a full list
         row_out.count = n;
      end else if (n == ins.keep) begin
         row_out.count = n;
      end else begin
         row_out.count = n + CNT_W'(1);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/pwtk_drain.sv
// drain engine: holds a window's list, sends it best first, a beat per entry or one empty beat
// depends on pwtk_pkg
`default_nettype none

module pwtk_drain (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire pwtk_pkg::drain_load_type            ld,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [pwtk_pkg::RSP_DATA_W-1:0]          rsp_tdata,  // out_window, out_id, out_score
   output logic [pwtk_pkg::RSP_USER_W-1:0]          rsp_tuser,  // entry_valid
   output logic                                     rsp_tlast
);
   import pwtk_pkg::*;

   entry_type [MAX_KEEP-1:0] list_ff, list_in;
   logic [CNT_W-1:0]         left_ff, left_in;
   logic [WIN_W-1:0]         win_ff, win_in;
   logic                     empty_ff, empty_in;
   logic                     active_ff, active_in;
   logic                     beat;
   entry_type                head;

   assign beat = active_ff && rsp_tready;

   always_comb begin
      list_in   = list_ff;
      left_in   = left_ff;
      win_in    = win_ff;
      empty_in  = empty_ff;
      active_in = active_ff;
      if (ld.load) begin
         list_in   = ld.ent;
         win_in    = ld.window;
         active_in = 1'b1;
         if (ld.count == '0) begin
            left_in  = CNT_W'(1);
            empty_in = 1'b1;
         end else begin
            left_in  = ld.count;
            empty_in = 1'b0;
         end
      end else if (beat) begin
         for (int i = 0; i < MAX_KEEP - 1; i++) begin
            list_in[i] = list_ff[i+1];
         end
         left_in = left_ff - CNT_W'(1);
         if (left_ff == CNT_W'(1)) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         left_ff   <= '0;
      end else begin
         active_ff <= active_in;
         left_ff   <= left_in;
      end
      list_ff  <= list_in;
      win_ff   <= win_in;
      empty_ff <= empty_in;
   end

   always_comb begin
      head = empty_ff ? '0 : list_ff[0];
   end

   assign rsp_tvalid = active_ff;
   assign rsp_tdata  = {head.score, head.id, win_ff};
   assign rsp_tuser  = RSP_USER_W'(!empty_ff);
   assign rsp_tlast  = (left_ff == CNT_W'(1));

endmodule

`default_nettype wire

FILE: dv/pwtk_checker.sv
// result checker for per_window_top_k_select: follows the request, result and register
// channels, keeps its own copy of every window's ranked list and compares each result beat
// depends on pwtk_pkg
`timescale 1ns / 1ps

module pwtk_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   input  wire logic                            req_tready,
   input  wire logic [pwtk_pkg::REQ_DATA_W-1:0] req_tdata,   // window, candidate_id, score
   input  wire logic [pwtk_pkg::REQ_USER_W-1:0] req_tuser,   // cmd, present
   input  wire logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   input  wire logic [pwtk_pkg::RSP_DATA_W-1:0] rsp_tdata,   // out_window, out_id, out_score
   input  wire logic [pwtk_pkg::RSP_USER_W-1:0] rsp_tuser,   // entry_valid
   input  wire logic                            rsp_tlast,
   input  wire logic                            csr_valid,
   input  wire logic                            csr_ready,
   input  wire logic [pwtk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [pwtk_pkg::CSR_DATA_W-1:0] csr_data,
   output int                                   mismatch_count,
   output int                                   beats_waiting,
   output int                                   beats_checked
);
   import pwtk_pkg::*;

   typedef struct packed {
      logic [7:0]                window;
      logic [ID_W-1:0]           id;
      logic signed [SCORE_W-1:0] score;
      logic                      entry_valid;
      logic                      last;
   } drain_beat_type;

   logic [KEEP_W-1:0]         keep_reg;
   logic [WCOUNT_W-1:0]       window_limit;
   int                        list_len   [MAX_WINDOWS];
   logic signed [SCORE_W-1:0] list_score [MAX_WINDOWS][MAX_KEEP];
   logic [ID_W-1:0]           list_id    [MAX_WINDOWS][MAX_KEEP];
   drain_beat_type            drain_beats_q [$];
   int                        errors = 0;
   int                        checked = 0;

   function automatic int keep_limit();
      return (keep_reg > MAX_KEEP) ? MAX_KEEP : int'(keep_reg);
   endfunction

   function automatic int held_entries(input int w);
      return (list_len[w] > keep_limit()) ? keep_limit() : list_len[w];
   endfunction

   task automatic append_beat(input drain_beat_type b);
      drain_beats_q.insert(drain_beats_q.size(), b);
   endtask

   // sorted insertion; equal scores stay behind older ones, so a tie with the
   // weakest entry of a full list falls off the end
   task automatic rank_candidate(input int w, input logic [ID_W-1:0] id,
                                 input logic signed [SCORE_W-1:0] score);
      int lim;
      int n;
      int p;
      int i;
      lim = keep_limit();
      n   = held_entries(w);
      if (lim == 0) begin
         list_len[w] = 0;
         return;
      end
      p = 0;
      while (p < n && list_score[w][p] >= score) p++;
      if (p >= lim) begin
         list_len[w] = n;
         return;
      end
      if (n == lim) n = lim - 1;
      for (i = n; i > p; i--) begin
         list_score[w][i] = list_score[w][i-1];
         list_id[w][i]    = list_id[w][i-1];
      end
      list_score[w][p] = score;
      list_id[w][p]    = id;
      list_len[w]      = n + 1;
   endtask

   task automatic predict_drain(input int w);
      drain_beat_type b;
      int             n;
      int             k;
      n = 0;
      if (w < window_limit) begin
         n = held_entries(w);
         list_len[w] = 0;
      end
      b = '0;
      b.window = 8'(w);
      if (n == 0) begin
         b.last = 1'b1;
         append_beat(b);
      end else begin
         for (k = 0; k < n; k++) begin
            b.id          = list_id[w][k];
            b.score       = list_score[w][k];
            b.entry_valid = 1'b1;
            b.last        = (k + 1 == n);
            append_beat(b);
         end
      end
   endtask

   function automatic void compare_field(input string what, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, what, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      drain_beat_type want;
      drain_beat_type got;
      if (reset) begin
         keep_reg     = 5'd16;
         window_limit = 9'd256;
         foreach (list_len[w]) list_len[w] = 0;
         drain_beats_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_KEEP:    keep_reg     = csr_data[KEEP_W-1:0];
               CSR_WINDOWS: window_limit = csr_data[WCOUNT_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.window      = rsp_tdata[WINDOW_LSB +: 8];
            got.id          = rsp_tdata[ID_LSB +: ID_W];
            got.score       = rsp_tdata[SCORE_LSB +: SCORE_W];
            got.entry_valid = rsp_tuser[0];
            got.last        = rsp_tlast;
            if (drain_beats_q.size() == 0) begin
               $display("%0t: unexpected result beat, expected none actual %h", $time, got);
               errors++;
            end else begin
               want = drain_beats_q.pop_front();
               compare_field("out_window", 32'(want.window), 32'(got.window));
               compare_field("out_id", 32'(want.id), 32'(got.id));
               compare_field("out_score", want.score, got.score);
               compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
               compare_field("last", 32'(want.last), 32'(got.last));
            end
            checked++;
         end
         if (req_tvalid && req_tready) begin
            if (cmd_type'(req_tuser[0]) == CMD_DRAIN)
               predict_drain(int'(req_tdata[WINDOW_LSB +: 8]));
            else if (req_tuser[1] && req_tdata[WINDOW_LSB +: 8] < window_limit)
               rank_candidate(int'(req_tdata[WINDOW_LSB +: 8]), req_tdata[ID_LSB +: ID_W],
                              req_tdata[SCORE_LSB +: SCORE_W]);
         end
      end
      mismatch_count <= errors;
      beats_waiting  <= drain_beats_q.size();
      beats_checked  <= checked;
   end

endmodule

FILE: dv/tb_top.sv
// testbench top for per_window_top_k_select: clock, reset, request and register stimulus,
// result back-pressure and the verdict; checking is done by pwtk_checker
`timescale 1ns / 1ps

module tb_top;
   import pwtk_pkg::*;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [REQ_USER_W-1:0] req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [RSP_USER_W-1:0] rsp_tuser;
   logic                  rsp_tlast;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   int mismatch_count;
   int beats_waiting;
   int beats_checked;

   int items_sent = 0;
   int drains_sent = 0;
   int settings_used = 0;
   int gap_pct = 0;
   int stall_pct = 0;
   bit choke_sink = 1'b0;

   per_window_top_k_select DUT (.*);

   pwtk_checker u_checker (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #2_000_000;
      $display("timeout at %0t with %0d result beats outstanding", $time, beats_waiting);
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall bursts, plus one long hold-off on request
   initial begin : sink
      bit choke_done;
      choke_done = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         if (choke_sink && !choke_done) begin
            choke_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (300) @(posedge clock);
         end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send(input cmd_type cmd, input logic [7:0] w, input logic [ID_W-1:0] id,
                       input logic signed [SCORE_W-1:0] score, input logic present);
      if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {score, id, w};
      req_tuser  <= {present, cmd};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      if (cmd == CMD_DRAIN) drains_sent++;
   endtask

   // wait until every expected beat is in and any trailing insert has finished
   task automatic drain_out();
      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (beats_waiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_registers(input int keep, input int windows);
      drain_out();
      csr_valid <= 1'b1;
      csr_index <= CSR_KEEP;
      csr_data  <= 9'(keep);
      do @(posedge clock); while (!csr_ready);
      csr_index <= CSR_WINDOWS;
      csr_data  <= 9'(windows);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      settings_used++;
   endtask

   initial begin : stimulus
      int                        keeps   [9] = '{16, 3, 1, 31, 16, 7, 5, 0, 16};
      int                        windows [9] = '{256, 6, 3, 511, 1, 300, 0, 0, 256};
      int                        lim;
      int                        hot_top;
      int                        pick;
      logic [7:0]                w;
      logic signed [SCORE_W-1:0] sc;

      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_KEEP;
      csr_data  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: empty window, absent slot, score extremes, ties in arrival order
      send(CMD_DRAIN,  8'd0,   16'h0000, 32'sd0,        1'b0);
      send(CMD_INSERT, 8'd0,   16'h0001, 32'sd100,      1'b0);
      send(CMD_INSERT, 8'd0,   16'hffff, 32'h7fffffff,  1'b1);
      send(CMD_INSERT, 8'd0,   16'h0000, 32'h80000000,  1'b1);
      send(CMD_INSERT, 8'd0,   16'h1234, 32'sd0,        1'b1);
      send(CMD_INSERT, 8'd0,   16'h1235, 32'sd0,        1'b1);
      send(CMD_INSERT, 8'd255, 16'haaaa, -32'sd1,       1'b1);
      send(CMD_DRAIN,  8'd0,   16'h0000, 32'sd0,        1'b1);
      send(CMD_DRAIN,  8'd255, 16'hffff, 32'hffffffff,  1'b1);
      for (int i = 0; i < 4; i++)
         send(CMD_INSERT, 8'd3, 16'h7001 + 16'(i), 32'(40 - 10 * i), 1'b1);

      // keep lowered below a window's fill, tie with the weakest of a full list,
      // windows past the count
      set_registers(2, 4);
      send(CMD_INSERT, 8'd3, 16'h7005, 32'sd25, 1'b1);
      send(CMD_INSERT, 8'd1, 16'h0001, 32'sd10, 1'b1);
      send(CMD_INSERT, 8'd1, 16'h0002, 32'sd10, 1'b1);
      send(CMD_INSERT, 8'd1, 16'h0003, 32'sd10, 1'b1);
      send(CMD_DRAIN,  8'd1, 16'h0000, 32'sd0,  1'b1);
      send(CMD_INSERT, 8'd5, 16'h5555, 32'sd9,  1'b1);
      send(CMD_DRAIN,  8'd5, 16'h0000, 32'sd0,  1'b1);

      // keep raised again: the trimmed entries stay gone
      set_registers(31, 256);
      send(CMD_DRAIN, 8'd3, 16'h0000, 32'sd0, 1'b1);

      // zero keep drops everything
      set_registers(0, 256);
      send(CMD_INSERT, 8'd2, 16'h0202, 32'sd1, 1'b1);
      send(CMD_DRAIN,  8'd2, 16'h0000, 32'sd0, 1'b1);

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 7) begin
            keeps[ph]   = $urandom_range(0, 31);
            windows[ph] = $urandom_range(1, 511);
         end
         set_registers(keeps[ph], windows[ph]);
         gap_pct   = (ph == 8) ? 0 : $urandom_range(0, 30);
         stall_pct = (ph == 8) ? 0 : $urandom_range(0, 30);
         lim       = (windows[ph] > MAX_WINDOWS) ? MAX_WINDOWS : windows[ph];
         hot_top   = (lim == 0) ? 3 : ((lim > 4) ? 3 : lim - 1);
         for (int n = 0; n < 40; n++) begin
            // long hold-off on the result side while requests keep coming
            if (ph == 0 && n == 10) choke_sink = 1'b1;
            pick = $urandom_range(0, 19);
            if (pick < 15)
               w = 8'($urandom_range(0, hot_top));
            else if (pick < 17)
               w = 8'((lim + $urandom_range(0, 2) > 256) ? 255 : lim + $urandom_range(0, 2) - 1);
            else
               w = 8'($urandom_range(0, 255));
            pick = $urandom_range(0, 9);
            if (pick < 3)
               sc = 32'($urandom_range(0, 4)) - 32'sd2;
            else if (pick == 3)
               case ($urandom_range(0, 3))
                  0:       sc = 32'h7fffffff;
                  1:       sc = 32'h80000000;
                  2:       sc = 32'sd0;
                  default: sc = -32'sd1;
               endcase
            else
               sc = $urandom;
            if ($urandom_range(0, 7) == 0)
               send(CMD_DRAIN, w, 16'($urandom), sc, 1'($urandom));
            else
               send(CMD_INSERT, w, 16'($urandom), sc, $urandom_range(0, 11) != 0);
         end
         for (int h = 0; h <= hot_top; h++)
            send(CMD_DRAIN, 8'(h), 16'($urandom), $urandom, 1'b1);
      end

      req_tvalid <= 1'b0;
      repeat (2) @(posedge clock);
      while (beats_waiting != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("covered %0d requests (%0d drains) across %0d register settings",
               items_sent, drains_sent, settings_used);
      $display("%0d result beats compared, %0d mismatches, %0d beats never seen",
               beats_checked, mismatch_count, beats_waiting);
      if (mismatch_count == 0 && beats_waiting == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
